FILE: hw/rtl/kpd_pkg.sv
`default_nettype none

package kpd_pkg;

	// item operation
	typedef enum logic {
		OP_SCAN = 1'b0,
		OP_READ = 1'b1
	} op_t;

	// configuration register indexes
	localparam logic CFG_STABLE_SAMPLES = 1'b0;
	localparam logic CFG_TICK_MS        = 1'b1;

	localparam int unsigned CODE_W = 5;
	localparam logic [CODE_W-1:0] NO_KEY = 5'd16;
	localparam logic [7:0] COUNT_MAX = 8'hFF;

	// reset values of the registers
	localparam logic [7:0] STABLE_SAMPLES_RST = 8'd2;
	localparam logic [9:0] TICK_MS_RST        = 10'd10;

	// key characters indexed by 4*row + col
	localparam logic [7:0] KEY_MAP [16] = '{
		8'h31, 8'h32, 8'h33, 8'h41,
		8'h34, 8'h35, 8'h36, 8'h42,
		8'h37, 8'h38, 8'h39, 8'h43,
		8'h2A, 8'h30, 8'h23, 8'h44
	};

	// first low row level, lowest column then lowest row, as 4*row + col
	function automatic logic [CODE_W-1:0] encode_first_key(input logic [15:0] levels);
		logic [CODE_W-1:0] code;
		logic [3:0]        pos;
		code = NO_KEY;
		for (int i = 15; i >= 0; i--) begin
			if (!levels[i]) begin
				pos  = 4'(i);
				code = {1'b0, pos[1:0], pos[3:2]};
			end
		end
		return code;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/keypad_scan_debounce_latch_core.sv
// channel | signals                                    | direction
// --------+--------------------------------------------+----------
// in      | in_valid, in_ready, operation, row_levels  | into core
// out     | out_valid, out_ready, key_char, key_valid, | out of core
//         | key_pending, time_ms                       |
// cfg     | cfg_we, cfg_index, cfg_data                | into core
//
// one word per cycle while the output side drains: a word is decoded and folded
// into the state at its accept edge, which also loads its result into the output register.
// the output register decouples the sides: a new word is taken whenever the
// register is empty or drained in the same cycle.
// asynchronous reset clears all key state, the clock and out_valid; the cfg registers take their reset values.
`default_nettype none

module keypad_scan_debounce_latch_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input words
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        operation,
	input  wire logic [15:0] row_levels,
	// result words
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [7:0]       key_char,
	output logic             key_valid,
	output logic             key_pending,
	output logic [31:0]      time_ms,
	// configuration writes
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [9:0]  cfg_data
);

	logic [7:0]  stable_samples_q;
	logic [9:0]  tick_ms_q;

	logic [kpd_pkg::CODE_W-1:0] previous_code_q;
	logic [kpd_pkg::CODE_W-1:0] reported_code_q;
	logic [7:0]  stable_count_q;
	logic [7:0]  pending_char_q;
	logic        pending_q;
	logic [31:0] clock_ms_q;

	logic        in_fire;
	logic        is_read;

	logic [kpd_pkg::CODE_W-1:0] code;
	logic [kpd_pkg::CODE_W-1:0] previous_code_d;
	logic [kpd_pkg::CODE_W-1:0] reported_code_d;
	logic [7:0]  stable_count_d;
	logic [7:0]  pending_char_d;
	logic        pending_d;
	logic [31:0] clock_ms_d;
	logic [7:0]  key_char_d;
	logic        key_valid_d;

	assign in_ready = !out_valid || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign is_read  = (operation == kpd_pkg::OP_READ);
	assign code     = kpd_pkg::encode_first_key(row_levels);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_samples_q <= kpd_pkg::STABLE_SAMPLES_RST;
			tick_ms_q        <= kpd_pkg::TICK_MS_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kpd_pkg::CFG_STABLE_SAMPLES: stable_samples_q <= cfg_data[7:0];
				kpd_pkg::CFG_TICK_MS:        tick_ms_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// next state for one word: debounce on a scan, consume on a read
	always_comb begin
		previous_code_d = previous_code_q;
		reported_code_d = reported_code_q;
		stable_count_d  = stable_count_q;
		pending_char_d  = pending_char_q;
		pending_d       = pending_q;
		clock_ms_d      = clock_ms_q;
		key_char_d      = 8'd0;
		key_valid_d     = 1'b0;
		if (!is_read) begin
			clock_ms_d = clock_ms_q + {22'd0, tick_ms_q};
			if (code == previous_code_q) begin
				if (stable_count_q != kpd_pkg::COUNT_MAX) begin
					stable_count_d = stable_count_q + 8'd1;
				end
			end else begin
				previous_code_d = code;
				stable_count_d  = 8'd0;
			end
			if (stable_count_d == stable_samples_q && code != reported_code_q) begin
				reported_code_d = code;
				if (code != kpd_pkg::NO_KEY && !pending_q) begin
					pending_char_d = kpd_pkg::KEY_MAP[code[3:0]];
					pending_d      = 1'b1;
				end
			end
		end else if (pending_q) begin
			key_char_d     = pending_char_q;
			key_valid_d    = 1'b1;
			pending_char_d = 8'd0;
			pending_d      = 1'b0;
		end
	end

	// key state and clock
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			previous_code_q <= kpd_pkg::NO_KEY;
			reported_code_q <= kpd_pkg::NO_KEY;
			stable_count_q  <= 8'd0;
			pending_char_q  <= 8'd0;
			pending_q       <= 1'b0;
			clock_ms_q      <= 32'd0;
		end else if (in_fire) begin
			previous_code_q <= previous_code_d;
			reported_code_q <= reported_code_d;
			stable_count_q  <= stable_count_d;
			pending_char_q  <= pending_char_d;
			pending_q       <= pending_d;
			clock_ms_q      <= clock_ms_d;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (in_ready) begin
			out_valid <= in_valid;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			key_char    <= key_char_d;
			key_valid   <= key_valid_d;
			key_pending <= pending_d;
			time_ms     <= clock_ms_d;
		end
	end

	// a consumed key is never a blank character
	a_valid_char: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && key_valid |-> key_char != 8'd0)
		else $error("consumed key without character");

	// an empty latch holds no character
	a_empty_latch: assert property (@(posedge clk) disable iff (!arst_n)
		!pending_q |-> pending_char_q == 8'd0)
		else $error("character left in empty latch");

	// a read with a key pending empties the latch
	a_read_consumes: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && is_read && pending_q |=> !pending_q && out_valid && key_valid)
		else $error("read did not consume pending key");

	// a scan advances the clock by the tick length
	a_clock_step: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && !is_read |=>
			clock_ms_q == $past(clock_ms_q) + {22'd0, $past(tick_ms_q)})
		else $error("clock did not advance by one tick");

endmodule

`default_nettype wire

FILE: tb/sv/keypad_scan_debounce_latch_core_tb.sv
`timescale 1ns / 1ps

module keypad_scan_debounce_latch_core_tb;

	// one result word as seen on the output side
	typedef struct packed {
		logic [7:0]  ch;
		logic        vld;
		logic        pend;
		logic [31:0] ms;
	} key_word_t;

	// directed stimulus row, with a typed result where it is obvious
	typedef struct packed {
		kpd_pkg::op_t op;
		logic [15:0]  lv;
		logic         typed;
		key_word_t    want;
	} step_row_t;

	localparam int NUM_ROWS = 23;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        operation;
	logic [15:0] row_levels;
	logic        out_valid;
	logic        out_ready;
	logic [7:0]  key_char;
	logic        key_valid;
	logic        key_pending;
	logic [31:0] time_ms;
	logic        cfg_we;
	logic        cfg_index;
	logic [9:0]  cfg_data;

	// keypad shadow state
	logic [7:0]  stable_thr;
	logic [9:0]  tick_len;
	logic [4:0]  last_code;
	logic [7:0]  run_len;
	logic [4:0]  held_code;
	logic [7:0]  latched_char;
	logic        latched;
	logic [31:0] now_ms;
	string       key_chars = "123A456B789C*0#D";

	key_word_t   key_results_q[$];
	int unsigned mismatches;
	int unsigned words_sent;
	int unsigned rx_hold;
	bit          tx_burst;

	step_row_t directed_rows [NUM_ROWS] = '{
		'{kpd_pkg::OP_READ, 16'hFFFF, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd0}},
		'{kpd_pkg::OP_SCAN, 16'hFFFF, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd10}},
		'{kpd_pkg::OP_SCAN, 16'hFFFF, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd20}},
		'{kpd_pkg::OP_SCAN, 16'hFFFE, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'hFFFE, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'hFFFE, 1'b0, '0},
		'{kpd_pkg::OP_READ, 16'h0000, 1'b1, '{8'h31, 1'b1, 1'b0, 32'd50}},
		'{kpd_pkg::OP_READ, 16'hFFFF, 1'b1, '{8'h00, 1'b0, 1'b0, 32'd50}},
		'{kpd_pkg::OP_SCAN, 16'h0000, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'h7FFF, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'h7FFF, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'h7FFF, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'hEFFF, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'hEFFF, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'hEFFF, 1'b0, '0},
		'{kpd_pkg::OP_READ, 16'h1234, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'hFFFF, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'hFFFF, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'hFFFF, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'h07FF, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'h07FF, 1'b0, '0},
		'{kpd_pkg::OP_SCAN, 16'h07FF, 1'b0, '0},
		'{kpd_pkg::OP_READ, 16'hFFFF, 1'b0, '0}
	};

	keypad_scan_debounce_latch_core DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.operation   (operation),
		.row_levels  (row_levels),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.key_char    (key_char),
		.key_valid   (key_valid),
		.key_pending (key_pending),
		.time_ms     (time_ms),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	// 100 MHz clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// lowest column first, then lowest row
	function automatic logic [4:0] first_pressed(input logic [15:0] lv);
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (!lv[4*c + r])
					return 5'(4*r + c);
			end
		end
		return kpd_pkg::NO_KEY;
	endfunction

	// fold one accepted word into the shadow state and build its result
	task automatic advance_keypad(input kpd_pkg::op_t op, input logic [15:0] lv,
			output key_word_t w);
		logic [4:0] code;
		w = '0;
		if (op == kpd_pkg::OP_SCAN) begin
			now_ms = now_ms + 32'(tick_len);
			code = first_pressed(lv);
			if (code == last_code) begin
				if (run_len != kpd_pkg::COUNT_MAX)
					run_len = run_len + 8'd1;
			end else begin
				last_code = code;
				run_len = 8'd0;
			end
			// debounced state change, character dropped if one is waiting
			if (run_len == stable_thr && code != held_code) begin
				held_code = code;
				if (code != kpd_pkg::NO_KEY && !latched) begin
					latched_char = key_chars[int'(code)];
					latched = 1'b1;
				end
			end
		end else if (latched) begin
			w.ch = latched_char;
			w.vld = 1'b1;
			latched_char = 8'd0;
			latched = 1'b0;
		end
		w.pend = latched;
		w.ms = now_ms;
	endtask

	// offer one input word, record its result at the accept edge
	task automatic send_word(input kpd_pkg::op_t op, input logic [15:0] lv,
			input logic typed, input key_word_t want);
		int unsigned gap;
		key_word_t w;
		gap = tx_burst ? 0 : $urandom_range(0, 9);
		repeat (gap) begin
			@(negedge clk);
			in_valid <= 1'b0;
		end
		@(negedge clk);
		in_valid <= 1'b1;
		operation <= op;
		row_levels <= lv;
		do @(posedge clk); while (!in_ready);
		advance_keypad(op, lv, w);
		if (typed)
			w = want;
		key_results_q.push_back(w);
		words_sent++;
	endtask

	task automatic send_scan(input logic [15:0] lv);
		send_word(kpd_pkg::OP_SCAN, lv, 1'b0, '0);
	endtask

	task automatic send_read();
		send_word(kpd_pkg::OP_READ, 16'($urandom), 1'b0, '0);
	endtask

	// stop offering and let every outstanding result come back
	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (key_results_q.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_cfg(input logic idx, input logic [9:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == kpd_pkg::CFG_STABLE_SAMPLES)
			stable_thr = val[7:0];
		else
			tick_len = val;
	endtask

	// press one key long enough to settle (or bounce short), then release
	task automatic key_press();
		int unsigned pos;
		int unsigned hold;
		logic [15:0] lv;
		pos = $urandom_range(0, 15);
		if ($urandom_range(0, 4) == 0)
			hold = $urandom_range(1, int'(stable_thr) + 1);
		else
			hold = int'(stable_thr) + 1 + $urandom_range(0, 2);
		repeat (hold) begin
			// extra low bits only where they lose the priority encode
			lv = 16'($urandom) | ((16'h1 << pos) - 16'h1);
			lv[pos] = 1'b0;
			if ($urandom_range(0, 19) == 0)
				lv = 16'($urandom);
			send_scan(lv);
			if ($urandom_range(0, 5) == 0)
				send_read();
		end
		repeat (int'(stable_thr) + 1 + $urandom_range(0, 2)) begin
			send_scan(16'hFFFF);
			if ($urandom_range(0, 7) == 0)
				send_read();
		end
		if ($urandom_range(0, 1) == 0)
			send_read();
	endtask

	task automatic run_phase(input logic [7:0] thr, input logic [9:0] tick,
			input int unsigned n);
		int unsigned stop_at;
		drain();
		write_cfg(kpd_pkg::CFG_STABLE_SAMPLES, {2'b00, thr});
		write_cfg(kpd_pkg::CFG_TICK_MS, tick);
		stop_at = words_sent + n;
		while (words_sent < stop_at) begin
			tx_burst = ($urandom_range(0, 3) == 0);
			case ($urandom_range(0, 9))
				0: begin
					// noise
					repeat ($urandom_range(1, 6))
						send_word(kpd_pkg::op_t'($urandom_range(0, 1)), 16'($urandom),
							1'b0, '0);
				end
				1: send_read();
				default: key_press();
			endcase
			if ($urandom_range(0, 15) == 0)
				drain();
		end
	endtask

	// result side: random stalls, long hold-off on request
	initial begin
		int unsigned stall;
		bit          rx_burst;
		key_word_t   got;
		key_word_t   exp_w;
		out_ready = 1'b0;
		rx_burst = 1'b0;
		forever begin
			if (rx_hold != 0) begin
				repeat (rx_hold) begin
					@(negedge clk);
					out_ready <= 1'b0;
				end
				rx_hold = 0;
			end
			if ($urandom_range(0, 39) == 0)
				rx_burst = !rx_burst;
			stall = rx_burst ? 0 : $urandom_range(0, 9);
			repeat (stall) begin
				@(negedge clk);
				out_ready <= 1'b0;
			end
			@(negedge clk);
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			got = '{key_char, key_valid, key_pending, time_ms};
			if (key_results_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word: char %h valid %b pend %b ms %0d",
						got.ch, got.vld, got.pend, got.ms);
			end else begin
				exp_w = key_results_q.pop_front();
				if (got !== exp_w) begin
					mismatches++;
					if (mismatches <= 10)
						$display({"mismatch: expected char %h valid %b pend %b ms %0d,",
							" got char %h valid %b pend %b ms %0d"},
							exp_w.ch, exp_w.vld, exp_w.pend, exp_w.ms,
							got.ch, got.vld, got.pend, got.ms);
				end
			end
		end
	end

	// run limit
	initial begin
		#5_000_000;
		$display("Some tests failed");
		$finish;
	end

	// stimulus
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = kpd_pkg::OP_SCAN;
		row_levels = 16'hFFFF;
		cfg_we = 1'b0;
		cfg_index = kpd_pkg::CFG_STABLE_SAMPLES;
		cfg_data = 10'd0;
		mismatches = 0;
		words_sent = 0;
		rx_hold = 0;
		tx_burst = 1'b0;
		stable_thr = kpd_pkg::STABLE_SAMPLES_RST;
		tick_len = kpd_pkg::TICK_MS_RST;
		last_code = kpd_pkg::NO_KEY;
		run_len = 8'd0;
		held_code = kpd_pkg::NO_KEY;
		latched_char = 8'd0;
		latched = 1'b0;
		now_ms = 32'd0;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;

		// directed words at reset settings
		foreach (directed_rows[i])
			send_word(directed_rows[i].op, directed_rows[i].lv, directed_rows[i].typed,
				directed_rows[i].want);

		// result side held off while words keep coming back to back
		drain();
		rx_hold = 120;
		tx_burst = 1'b1;
		repeat (20)
			send_scan(16'($urandom));
		drain();

		run_phase(8'd0, 10'd1, 250);
		run_phase(8'd1, 10'd1000, 250);
		run_phase(8'd255, 10'd1023, 560);
		run_phase(8'd2, 10'd0, 150);
		run_phase(8'd3, 10'd517, 200);
		run_phase(8'($urandom_range(0, 6)), 10'($urandom_range(1, 1023)), 200);

		drain();
		repeat (5) @(posedge clk);
		mismatches += key_results_q.size();
		if (mismatches == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
